// ----- rtl/core/parabolic_peak_refiner_core_macros.svh -----
// Assertion macros for the peak refiner checker.
`ifndef PARABOLIC_PEAK_REFINER_CORE_MACROS_SVH
`define PARABOLIC_PEAK_REFINER_CORE_MACROS_SVH

// Checked outside reset.
`define PPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ppr_pkg.sv -----
`default_nettype none
package ppr_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int IDX_W    = 13;
  localparam int SAMPLE_W = 32;
  localparam int NUM_W    = 13;

  // |y1 - y3| and |y1 - 2*y2 + y3| widths
  localparam int NUM_MAG_W = 33;
  localparam int D_MAG_W   = 34;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

// ----- rtl/core/ppr_trace_mem.sv -----
`default_nettype none
module ppr_trace_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/ppr_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit a cycle.
module ppr_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [FRAC_BITS+33:0]   dividend,
  input  wire logic [34:0]             divisor,
  output logic [FRAC_BITS+33:0]        quotient,
  output logic                         done
);

  localparam int DW = FRAC_BITS + 34;
  localparam int VW = 35;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_sub  = rem_sh - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ----- rtl/core/ppr_mul.sv -----
`default_nettype none
// Shift-add multiplier, multiplier bits taken MSB first, with sticky overflow.
module ppr_mul #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [32:0]           mag_a,
  input  wire logic [FRAC_BITS+33:0] mag_b,
  output logic [FRAC_BITS+35:0]      product,
  output logic                       ovf,
  output logic                       done
);

  localparam int AW_  = ppr_pkg::NUM_MAG_W;
  localparam int BW   = FRAC_BITS + 34;
  localparam int LIM  = FRAC_BITS + 36;
  localparam int CW   = $clog2(AW_ + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW_-1:0] a_r, a_nxt;
  logic [BW-1:0]  b_r, b_nxt;
  logic [LIM-1:0] acc_r, acc_nxt;
  logic [LIM+1:0] sum;

  always_comb begin
    sum      = (LIM+2)'({acc_r, 1'b0}) + (a_r[AW_-1] ? (LIM+2)'(b_r) : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
      cnt_nxt  = CW'(AW_);
      a_nxt    = mag_a;
      b_nxt    = mag_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sum[LIM-1:0];
      a_nxt   = {a_r[AW_-2:0], 1'b0};
      // product only grows, so an overflow here stays one
      if (sum[LIM+1:LIM] != 2'b00) begin
        ovf_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ovf_r <= ovf_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign product = acc_r;
  assign ovf     = ovf_r;
  assign done    = done_r;

endmodule
`default_nettype wire

// ----- rtl/core/parabolic_peak_refiner_core.sv -----
`default_nettype none
// Write word: accepted while idle, in_tready stays high.
// Query word: three registered trace reads (one for an edge index), a serial
// divide of FRAC_BITS+34 steps and a serial multiply of 33 steps, both skipped
// for an edge index or flat samples; out_tvalid rises as the FSM leaves S_FIN.
// in_tready returns with out_tvalid, later while the previous result is held.
// Synchronous active-low reset clears control and sets num_samples to 4096;
// trace contents are not cleared.
module parabolic_peak_refiner_core #(
  parameter int TRACE_DEPTH = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,   // num_samples
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,    // index[12:0], sample_value[44:13], zero pad
  input  wire logic        in_tuser,    // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata    // peak_position[31:0], peak_amplitude[63:32]
);

  localparam int AW   = $clog2(TRACE_DEPTH);
  localparam int NB   = $clog2(TRACE_DEPTH + 1);
  localparam int NCW  = (NB > ppr_pkg::NUM_W ? NB : ppr_pkg::NUM_W) + 1;
  localparam int DW   = FRAC_BITS + 34;
  localparam int LIM  = FRAC_BITS + 36;
  localparam int TW   = LIM - FRAC_BITS - 1;
  localparam int PSW  = FRAC_BITS + 36;
  localparam int ASW  = 37;
  localparam logic [LIM:0] HALF = (LIM+1)'(1) << (FRAC_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_R1   = 3'd1;
  localparam logic [2:0] S_R2   = 3'd2;
  localparam logic [2:0] S_R3   = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [12:0] num_samples_r;

  logic [NCW-1:0] n_eff, ns_ext, idx_u;
  logic signed [12:0] in_idx;
  logic        in_acc, in_wr_ok, q_low, q_high;

  logic [NCW-1:0] pos_idx_r, pos_idx_nxt;
  logic [NCW-1:0] mid_r, mid_nxt;
  logic        special_r, special_nxt;
  logic        use_corr_r, use_corr_nxt;
  logic        neg_r, neg_nxt;
  logic        dneg_r, dneg_nxt;
  logic signed [31:0] y1_r, y1_nxt, y2_r, y2_nxt, y3_r, y3_nxt;
  logic [32:0] an_r, an_nxt;
  logic [DW-1:0] q_r, q_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic signed [32:0] num_w;
  logic signed [33:0] d_w;
  logic [32:0] an_w;
  logic [33:0] ad_w;
  logic        div_start, div_done, mul_start, mul_done, mul_ovf;
  logic        div_go_r, mul_go_r;
  logic [DW-1:0]  div_dividend, div_quo;
  logic [34:0]    div_divisor;
  logic [LIM-1:0] mul_p;

  logic [LIM:0]   t_full;
  logic [TW-1:0]  t_w;
  logic signed [PSW-1:0] pos_w, pbase, qe;
  logic signed [ASW-1:0] amp_w, y2e, te;
  logic signed [31:0] pos_sat, amp_sat;

  function automatic logic signed [31:0] sat_pos(input logic signed [PSW-1:0] v);
    logic ok;
    ok = (v[PSW-1:31] == '0) || (v[PSW-1:31] == '1);
    return ok ? v[31:0] : (v[PSW-1] ? ppr_pkg::SAT_MIN : ppr_pkg::SAT_MAX);
  endfunction

  function automatic logic signed [31:0] sat_amp(input logic signed [ASW-1:0] v);
    logic ok;
    ok = (v[ASW-1:31] == '0) || (v[ASW-1:31] == '1);
    return ok ? v[31:0] : (v[ASW-1] ? ppr_pkg::SAT_MIN : ppr_pkg::SAT_MAX);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = $signed(in_tdata[12:0]);

  // clamp num_samples into [1, TRACE_DEPTH]
  always_comb begin
    ns_ext = NCW'(num_samples_r);
    if (ns_ext == '0) begin
      n_eff = NCW'(1);
    end else if (ns_ext > NCW'(TRACE_DEPTH)) begin
      n_eff = NCW'(TRACE_DEPTH);
    end else begin
      n_eff = ns_ext;
    end
  end

  assign idx_u    = NCW'(in_idx[11:0]);
  assign in_wr_ok = !in_idx[12] && (idx_u < n_eff);
  assign q_low    = in_idx[12] || (idx_u == '0);
  assign q_high   = !q_low && (idx_u >= n_eff - NCW'(1));

  always_comb begin
    num_w = 33'(y1_r) - 33'(y3_r);
    d_w   = 34'(y1_r) + 34'(y3_r) - (34'(y2_r) <<< 1);
    an_w  = num_w[32] ? 33'(-num_w) : 33'(num_w);
    ad_w  = d_w[33] ? 34'(-d_w) : 34'(d_w);
  end

  assign div_dividend = (DW'(an_r) << FRAC_BITS) + DW'(ad_w);
  assign div_divisor  = {ad_w, 1'b0};

  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (q_low) begin
          mem_raddr = '0;
        end else if (q_high) begin
          mem_raddr = n_eff[AW-1:0] - AW'(1);
        end else begin
          mem_raddr = idx_u[AW-1:0] - AW'(1);
        end
      end
      S_R1:    mem_raddr = mid_r[AW-1:0];
      S_R2:    mem_raddr = mid_r[AW-1:0] + AW'(1);
      default: mem_raddr = mid_r[AW-1:0];
    endcase
  end

  ppr_trace_mem #(.DEPTH(TRACE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (in_acc && (in_tuser == ppr_pkg::OP_WRITE) && in_wr_ok),
    .waddr (idx_u[AW-1:0]),
    .wdata (in_tdata[44:13]),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ppr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  ppr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mag_a   (an_r),
    .mag_b   (q_r),
    .product (mul_p),
    .ovf     (mul_ovf),
    .done    (mul_done)
  );

  // result arithmetic from held operands
  always_comb begin
    t_full = (LIM+1)'(mul_p) + HALF;
    t_w    = t_full[LIM:FRAC_BITS+2];
    pbase  = $signed(PSW'(pos_idx_r) << FRAC_BITS);
    qe     = $signed(PSW'(q_r));
    if (!use_corr_r) begin
      pos_w = pbase;
    end else if (neg_r) begin
      pos_w = pbase - qe;
    end else begin
      pos_w = pbase + qe;
    end
    y2e = ASW'(y2_r);
    te  = $signed({2'b00, t_w});
    if (!use_corr_r) begin
      amp_w = y2e;
    end else if (dneg_r) begin
      amp_w = y2e + te;
    end else begin
      amp_w = y2e - te;
    end
    pos_sat = sat_pos(pos_w);
    if (use_corr_r && mul_ovf) begin
      amp_sat = dneg_r ? ppr_pkg::SAT_MAX : ppr_pkg::SAT_MIN;
    end else begin
      amp_sat = sat_amp(amp_w);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_idx_nxt   = pos_idx_r;
    mid_nxt       = mid_r;
    special_nxt   = special_r;
    use_corr_nxt  = use_corr_r;
    neg_nxt       = neg_r;
    dneg_nxt      = dneg_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    y3_nxt        = y3_r;
    an_nxt        = an_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    div_start     = div_go_r;
    mul_start     = mul_go_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == ppr_pkg::OP_QUERY)) begin
          special_nxt  = q_low || q_high;
          use_corr_nxt = 1'b0;
          mid_nxt      = idx_u;
          if (q_low) begin
            pos_idx_nxt = '0;
          end else if (q_high) begin
            pos_idx_nxt = n_eff - NCW'(1);
          end else begin
            pos_idx_nxt = idx_u;
          end
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        if (special_r) begin
          y2_nxt    = mem_rdata;
          state_nxt = S_FIN;
        end else begin
          y1_nxt    = mem_rdata;
          state_nxt = S_R2;
        end
      end
      S_R2: begin
        y2_nxt    = mem_rdata;
        state_nxt = S_R3;
      end
      S_R3: begin
        y3_nxt    = mem_rdata;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        an_nxt   = an_w;
        neg_nxt  = num_w[32] != d_w[33];
        dneg_nxt = d_w[33];
        if (d_w == '0) begin
          state_nxt = S_FIN;
        end else begin
          use_corr_nxt = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {amp_sat, pos_sat};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // launch the serial units through registered go flags, after their operands settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_samples_r <= 13'd4096;
      out_valid_r   <= 1'b0;
      div_go_r      <= 1'b0;
      mul_go_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= (state_r == S_PREP) && (state_nxt == S_DIV);
      mul_go_r    <= (state_r == S_DIV) && (state_nxt == S_MUL);
      if (cfg_we) begin
        num_samples_r <= cfg_wdata;
      end
    end
    pos_idx_r  <= pos_idx_nxt;
    mid_r      <= mid_nxt;
    special_r  <= special_nxt;
    use_corr_r <= use_corr_nxt;
    neg_r      <= neg_nxt;
    dneg_r     <= dneg_nxt;
    y1_r       <= y1_nxt;
    y2_r       <= y2_nxt;
    y3_r       <= y3_nxt;
    an_r       <= an_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/core/ppr_checker.sv -----
`default_nettype none
`include "parabolic_peak_refiner_core_macros.svh"
module ppr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  `PPR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `PPR_ASSERT(a_query_busy, in_tvalid && in_tready && (in_tuser == ppr_pkg::OP_QUERY) |=> !in_tready, "ready right after a query")
  `PPR_ASSERT(a_write_fast, in_tvalid && in_tready && (in_tuser == ppr_pkg::OP_WRITE) |=> in_tready, "write word took more than one cycle")
  `PPR_ASSERT(a_result_frees, $rose(out_tvalid) |-> $rose(in_tready), "result shown without returning to ready")
  `PPR_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind parabolic_peak_refiner_core ppr_checker u_ppr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
